// File: rtl/lpcd_pkg.sv
// shared constants and register codes for the line pair corner detector
`default_nettype none
package lpcd_pkg;
  localparam int COORD_W             = 16;
  localparam int UNIT_W              = 16;
  localparam int TOL_W               = 12;
  localparam int CFG_IDX_W           = 3;
  localparam int CFG_DATA_W          = 16;
  localparam int COORD_FRAC_BITS_DEF = 4;
  localparam int TOL_PIXELS          = 15;

  localparam logic [CFG_IDX_W-1:0] REG_LEN_TOL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACUTE_LO  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACUTE_HI  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OBTUSE_LO = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OBTUSE_HI = 3'd4;

  localparam logic signed [UNIT_W-1:0] ACUTE_LO_RST  = 16'sd0;
  localparam logic signed [UNIT_W-1:0] ACUTE_HI_RST  = 16'sd8192;
  localparam logic signed [UNIT_W-1:0] OBTUSE_LO_RST = -16'sd8192;
  localparam logic signed [UNIT_W-1:0] OBTUSE_HI_RST = 16'sd0;
endpackage
`default_nettype wire

// File: rtl/lpcd_sqrt.sv
// pipelined integer square root, one root bit per stage
`default_nettype none
module lpcd_sqrt #(
  parameter int IN_W = 34
) (
  input  logic                clk,
  input  logic [IN_W-1:0]     rad,
  output logic [IN_W/2-1:0]   root
);
  localparam int OUT_W = IN_W / 2;
  localparam int REM_W = OUT_W + 3;

  logic [REM_W-1:0] rem_q  [OUT_W];
  logic [OUT_W-1:0] root_q [OUT_W];
  logic [IN_W-1:0]  rad_q  [OUT_W];

  genvar i;
  generate
    for (i = 0; i < OUT_W; i++) begin : g_stage
      logic [REM_W-1:0] rem_in;
      logic [REM_W-1:0] rem_sh;
      logic [REM_W-1:0] trial;
      logic [OUT_W-1:0] root_in;
      logic [IN_W-1:0]  rad_in;

      if (i == 0) begin : g_first
        assign rem_in  = '0;
        assign root_in = '0;
        assign rad_in  = rad;
      end else begin : g_next
        assign rem_in  = rem_q[i-1];
        assign root_in = root_q[i-1];
        assign rad_in  = rad_q[i-1];
      end

      assign rem_sh = {rem_in[REM_W-3:0], rad_in[IN_W-1 -: 2]};
      assign trial  = REM_W'({root_in, 2'b01});

      always_ff @(posedge clk) begin
        if (rem_sh >= trial) begin
          rem_q[i]  <= rem_sh - trial;
          root_q[i] <= {root_in[OUT_W-2:0], 1'b1};
        end else begin
          rem_q[i]  <= rem_sh;
          root_q[i] <= {root_in[OUT_W-2:0], 1'b0};
        end
        rad_q[i] <= {rad_in[IN_W-3:0], 2'b00};
      end
    end
  endgenerate

  assign root = root_q[OUT_W-1];
endmodule
`default_nettype wire

// File: rtl/lpcd_div.sv
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module lpcd_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 18,
  parameter int Q_W   = 15
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo
);
  localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [CW-1:0]    rem_q [Q_W];
  logic [DEN_W-1:0] den_q [Q_W];
  logic [Q_W-1:0]   quo_q [Q_W];

  genvar i;
  generate
    for (i = 0; i < Q_W; i++) begin : g_stage
      localparam int SH = Q_W - 1 - i;
      logic [CW-1:0]    rem_in;
      logic [CW-1:0]    shifted;
      logic [DEN_W-1:0] den_in;
      logic [Q_W-1:0]   quo_in;
      logic             geq;

      if (i == 0) begin : g_first
        assign rem_in = CW'(num);
        assign den_in = den;
        assign quo_in = '0;
      end else begin : g_next
        assign rem_in = rem_q[i-1];
        assign den_in = den_q[i-1];
        assign quo_in = quo_q[i-1];
      end

      assign shifted = CW'(den_in) << SH;
      assign geq     = rem_in >= shifted;

      always_ff @(posedge clk) begin
        rem_q[i] <= geq ? rem_in - shifted : rem_in;
        den_q[i] <= den_in;
        quo_q[i] <= {quo_in[Q_W-2:0], geq};
      end
    end
  endgenerate

  assign quo = quo_q[Q_W-1];
endmodule
`default_nettype wire

// File: rtl/line_pair_corner_detect.sv
// line pair corner detector: top level pipeline
// throughput: one segment pair per cycle while busy is low, depth set by the 17-stage
//   square root followed by the 15-stage unit-vector dividers
// reset: busy is high while rst is high, the pipeline empties, registers take defaults
// the receiver cannot stall; each result shows for one cycle with done
`default_nettype none
module line_pair_corner_detect #(
  parameter int COORD_FRAC_BITS = lpcd_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [lpcd_pkg::COORD_W-1:0]  first_start_x,
  input  logic signed [lpcd_pkg::COORD_W-1:0]  first_start_y,
  input  logic signed [lpcd_pkg::COORD_W-1:0]  first_end_x,
  input  logic signed [lpcd_pkg::COORD_W-1:0]  first_end_y,
  input  logic signed [lpcd_pkg::COORD_W-1:0]  second_start_x,
  input  logic signed [lpcd_pkg::COORD_W-1:0]  second_start_y,
  input  logic signed [lpcd_pkg::COORD_W-1:0]  second_end_x,
  input  logic signed [lpcd_pkg::COORD_W-1:0]  second_end_y,
  input  logic signed [lpcd_pkg::COORD_W-1:0]  first_grad_x,
  input  logic signed [lpcd_pkg::COORD_W-1:0]  first_grad_y,
  input  logic signed [lpcd_pkg::COORD_W-1:0]  second_grad_x,
  input  logic signed [lpcd_pkg::COORD_W-1:0]  second_grad_y,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lpcd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lpcd_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                 done,
  output logic                                 corner_valid,
  output logic signed [lpcd_pkg::COORD_W-1:0]  corner_x,
  output logic signed [lpcd_pkg::COORD_W-1:0]  corner_y,
  output logic signed [lpcd_pkg::UNIT_W-1:0]   left_dir_x,
  output logic signed [lpcd_pkg::UNIT_W-1:0]   left_dir_y,
  output logic signed [lpcd_pkg::UNIT_W-1:0]   right_dir_x,
  output logic signed [lpcd_pkg::UNIT_W-1:0]   right_dir_y,
  output logic                                 left_is_first
);
  localparam logic [lpcd_pkg::TOL_W-1:0] TOL_RST =
    lpcd_pkg::TOL_W'(lpcd_pkg::TOL_PIXELS << COORD_FRAC_BITS);

  typedef struct packed {
    logic signed [16:0] n1x;
    logic signed [16:0] n1y;
    logic signed [16:0] n2x;
    logic signed [16:0] n2y;
    logic signed [15:0] g1x;
    logic signed [15:0] g1y;
    logic signed [15:0] g2x;
    logic signed [15:0] g2y;
  } geo_t;

  typedef struct packed {
    logic signed [34:0] tna;
    logic signed [34:0] pna;
    logic [33:0]        c;
    logic               nz;
    logic               cneg;
    geo_t               geo;
  } side_a_t;

  typedef struct packed {
    logic               sgnx;
    logic               sgny;
    logic               ovx;
    logic               ovy;
    logic signed [15:0] s1x;
    logic signed [15:0] s1y;
  } side_c_t;

  typedef struct packed {
    logic               ok;
    logic               cneg;
    logic               h1;
    logic               h2;
    logic               s1x;
    logic               s1y;
    logic               s2x;
    logic               s2y;
    logic signed [15:0] g1x;
    logic signed [15:0] g1y;
    logic signed [15:0] g2x;
    logic signed [15:0] g2y;
  } side_d_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } pt_t;

  // configuration
  logic [lpcd_pkg::TOL_W-1:0]          tol;
  logic signed [lpcd_pkg::UNIT_W-1:0]  acl, ach, obl, obh;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RST;
      acl <= lpcd_pkg::ACUTE_LO_RST;
      ach <= lpcd_pkg::ACUTE_HI_RST;
      obl <= lpcd_pkg::OBTUSE_LO_RST;
      obh <= lpcd_pkg::OBTUSE_HI_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lpcd_pkg::REG_LEN_TOL:   tol <= cfg_data[lpcd_pkg::TOL_W-1:0];
        lpcd_pkg::REG_ACUTE_LO:  acl <= $signed(cfg_data);
        lpcd_pkg::REG_ACUTE_HI:  ach <= $signed(cfg_data);
        lpcd_pkg::REG_OBTUSE_LO: obl <= $signed(cfg_data);
        lpcd_pkg::REG_OBTUSE_HI: obh <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // handshake and valid chain
  logic        acc;
  logic [38:1] vld;

  assign acc = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      vld  <= '0;
      done <= 1'b0;
    end else begin
      busy <= 1'b0;
      vld  <= {vld[37:1], acc};
      done <= vld[38];
    end
  end

  // stage 1: direction vectors and start offset
  geo_t               geo_1, geo_2, geo_3;
  logic signed [16:0] dx_1, dy_1;
  logic signed [15:0] s1x_1, s1y_1, s1x_2, s1y_2, s1x_3, s1y_3, s1x_4, s1y_4;

  always_ff @(posedge clk) begin
    geo_1.n1x <= 17'(first_end_x) - 17'(first_start_x);
    geo_1.n1y <= 17'(first_end_y) - 17'(first_start_y);
    geo_1.n2x <= 17'(second_end_x) - 17'(second_start_x);
    geo_1.n2y <= 17'(second_end_y) - 17'(second_start_y);
    geo_1.g1x <= first_grad_x;
    geo_1.g1y <= first_grad_y;
    geo_1.g2x <= second_grad_x;
    geo_1.g2y <= second_grad_y;
    dx_1      <= 17'(second_start_x) - 17'(first_start_x);
    dy_1      <= 17'(second_start_y) - 17'(first_start_y);
    s1x_1     <= first_start_x;
    s1y_1     <= first_start_y;
  end

  // stage 2: products
  logic signed [33:0] pc1_2, pc2_2, pt1_2, pt2_2, pp1_2, pp2_2;
  logic signed [33:0] q1x_2, q1y_2, q2x_2, q2y_2;

  always_ff @(posedge clk) begin
    pc1_2 <= geo_1.n1x * geo_1.n2y;
    pc2_2 <= geo_1.n1y * geo_1.n2x;
    pt1_2 <= dx_1 * geo_1.n2y;
    pt2_2 <= dy_1 * geo_1.n2x;
    pp1_2 <= dx_1 * geo_1.n1y;
    pp2_2 <= dy_1 * geo_1.n1x;
    q1x_2 <= geo_1.n1x * geo_1.n1x;
    q1y_2 <= geo_1.n1y * geo_1.n1y;
    q2x_2 <= geo_1.n2x * geo_1.n2x;
    q2y_2 <= geo_1.n2y * geo_1.n2y;
    geo_2 <= geo_1;
    s1x_2 <= s1x_1;
    s1y_2 <= s1y_1;
  end

  // stage 3: cross product, line parameters and squared lengths
  logic signed [34:0] cross_3, tn_3, pn_3;
  logic [33:0]        sq1_3, sq2_3;

  always_ff @(posedge clk) begin
    cross_3 <= 35'(pc1_2) - 35'(pc2_2);
    tn_3    <= 35'(pt1_2) - 35'(pt2_2);
    pn_3    <= 35'(pp1_2) - 35'(pp2_2);
    sq1_3   <= $unsigned(q1x_2) + $unsigned(q1y_2);
    sq2_3   <= $unsigned(q2x_2) + $unsigned(q2y_2);
    geo_3   <= geo_2;
    s1x_3   <= s1x_2;
    s1y_3   <= s1y_2;
  end

  // stage 4: make the denominator positive
  side_a_t side_a [4:20];

  always_ff @(posedge clk) begin
    side_a[4].nz   <= cross_3 != '0;
    side_a[4].cneg <= cross_3[34];
    side_a[4].c    <= cross_3[34] ? 34'(-cross_3) : 34'(cross_3);
    side_a[4].tna  <= cross_3[34] ? -tn_3 : tn_3;
    side_a[4].pna  <= cross_3[34] ? -pn_3 : pn_3;
    side_a[4].geo  <= geo_3;
    s1x_4          <= s1x_3;
    s1y_4          <= s1y_3;
    for (int k = 5; k <= 20; k++) begin
      side_a[k] <= side_a[k-1];
    end
  end

  // segment lengths
  logic [16:0] len1_20, len2_20;

  lpcd_sqrt #(.IN_W(34)) u_sqrt1 (.clk(clk), .rad(sq1_3), .root(len1_20));
  lpcd_sqrt #(.IN_W(34)) u_sqrt2 (.clk(clk), .rad(sq2_3), .root(len2_20));

  // corner point path
  logic signed [51:0] mx_5, my_5;
  logic [33:0]        c_5, c_6;
  logic signed [15:0] s1x_5, s1y_5, s1x_6, s1y_6;
  logic [50:0]        magx_6, magy_6;
  logic               sgnx_6, sgny_6;
  logic [50:0]        numx_c, numy_c, numx_7, numy_7;
  logic [34:0]        den_7;
  side_c_t            side_c [7:24];

  always_comb begin
    numx_c = 51'({magx_6, 1'b0}) + 51'(c_6);
    numy_c = 51'({magy_6, 1'b0}) + 51'(c_6);
  end

  always_ff @(posedge clk) begin
    mx_5   <= side_a[4].tna * side_a[4].geo.n1x;
    my_5   <= side_a[4].tna * side_a[4].geo.n1y;
    c_5    <= side_a[4].c;
    s1x_5  <= s1x_4;
    s1y_5  <= s1y_4;
    magx_6 <= mx_5[51] ? 51'(-mx_5) : 51'(mx_5);
    magy_6 <= my_5[51] ? 51'(-my_5) : 51'(my_5);
    sgnx_6 <= mx_5[51];
    sgny_6 <= my_5[51];
    c_6    <= c_5;
    s1x_6  <= s1x_5;
    s1y_6  <= s1y_5;
    numx_7 <= numx_c;
    numy_7 <= numy_c;
    den_7  <= {c_6, 1'b0};
    // quotient of 2^17 or more always saturates the corner
    side_c[7].ovx <= 53'(numx_c) >= 53'({c_6, 18'b0});
    side_c[7].ovy <= 53'(numy_c) >= 53'({c_6, 18'b0});
    side_c[7].sgnx <= sgnx_6;
    side_c[7].sgny <= sgny_6;
    side_c[7].s1x  <= s1x_6;
    side_c[7].s1y  <= s1y_6;
    for (int k = 8; k <= 24; k++) begin
      side_c[k] <= side_c[k-1];
    end
  end

  logic [16:0] qx_24, qy_24;

  lpcd_div #(.NUM_W(51), .DEN_W(35), .Q_W(17)) u_div_cx (
    .clk(clk), .num(numx_7), .den(den_7), .quo(qx_24)
  );
  lpcd_div #(.NUM_W(51), .DEN_W(35), .Q_W(17)) u_div_cy (
    .clk(clk), .num(numy_7), .den(den_7), .quo(qy_24)
  );

  function automatic logic signed [15:0] corner_sat(
    input logic signed [15:0] base,
    input logic [16:0]        q,
    input logic               neg,
    input logic               ov
  );
    logic signed [18:0] qs;
    logic signed [18:0] sum;
    logic signed [15:0] res;
    qs  = $signed({2'b00, q});
    sum = 19'(base) + (neg ? -qs : qs);
    if (ov) begin
      res = neg ? 16'sh8000 : 16'sh7fff;
    end else if (sum > 19'sd32767) begin
      res = 16'sh7fff;
    end else if (sum < -19'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = 16'(sum);
    end
    return res;
  endfunction

  pt_t cpt [25:38];

  always_ff @(posedge clk) begin
    cpt[25].x <= corner_sat(side_c[24].s1x, qx_24, side_c[24].sgnx, side_c[24].ovx);
    cpt[25].y <= corner_sat(side_c[24].s1y, qy_24, side_c[24].sgny, side_c[24].ovy);
    for (int k = 26; k <= 38; k++) begin
      cpt[k] <= cpt[k-1];
    end
  end

  // endpoint tests
  function automatic logic [15:0] mag16(input logic signed [16:0] v);
    return v[16] ? 16'(-v) : 16'(v);
  endfunction

  function automatic logic near_end(
    input logic signed [52:0] al,
    input logic [50:0]        cl,
    input logic [45:0]        tc
  );
    logic signed [55:0] a;
    logic signed [55:0] c;
    logic signed [55:0] t;
    logic               lo;
    logic               hi;
    a  = 56'(al);
    c  = $signed({5'b0, cl});
    t  = $signed({10'b0, tc});
    lo = (a > -t) && ((a <<< 1) <= t);
    hi = ((a <<< 1) >= (c <<< 1) - t) && (a < c + t);
    return lo || hi;
  endfunction

  logic signed [52:0] al1_21, al2_21;
  logic [50:0]        cl1_21, cl2_21;
  logic [45:0]        tc_21;
  side_d_t            side_b_21;
  side_d_t            side_d [22:35];
  side_d_t            side_d_next;
  logic               lenok_21;

  always_comb begin
    side_d_next    = side_b_21;
    side_d_next.ok = side_b_21.ok && lenok_21 &&
                     near_end(al1_21, cl1_21, tc_21) &&
                     near_end(al2_21, cl2_21, tc_21);
  end

  always_ff @(posedge clk) begin
    al1_21 <= side_a[20].tna * $signed({1'b0, len1_20});
    al2_21 <= side_a[20].pna * $signed({1'b0, len2_20});
    cl1_21 <= side_a[20].c * len1_20;
    cl2_21 <= side_a[20].c * len2_20;
    tc_21  <= tol * side_a[20].c;
    lenok_21      <= (len1_20 != '0) && (len2_20 != '0);
    side_b_21.ok   <= side_a[20].nz;
    side_b_21.cneg <= side_a[20].cneg;
    side_b_21.h1   <= $signed({side_a[20].tna, 1'b0}) > $signed({2'b00, side_a[20].c});
    side_b_21.h2   <= $signed({side_a[20].pna, 1'b0}) > $signed({2'b00, side_a[20].c});
    side_b_21.s1x  <= side_a[20].geo.n1x[16];
    side_b_21.s1y  <= side_a[20].geo.n1y[16];
    side_b_21.s2x  <= side_a[20].geo.n2x[16];
    side_b_21.s2y  <= side_a[20].geo.n2y[16];
    side_b_21.g1x  <= side_a[20].geo.g1x;
    side_b_21.g1y  <= side_a[20].geo.g1y;
    side_b_21.g2x  <= side_a[20].geo.g2x;
    side_b_21.g2y  <= side_a[20].geo.g2y;

    side_d[22] <= side_d_next;
    for (int k = 23; k <= 35; k++) begin
      side_d[k] <= side_d[k-1];
    end
  end

  // unit vectors: round(|n| * 16384 / len), sign applied afterwards
  logic [31:0] un1x, un1y, un2x, un2y;
  logic [17:0] ud1, ud2;
  logic [14:0] q1x_35, q1y_35, q2x_35, q2y_35;

  assign un1x = 32'({mag16(side_a[20].geo.n1x), 15'b0}) + 32'(len1_20);
  assign un1y = 32'({mag16(side_a[20].geo.n1y), 15'b0}) + 32'(len1_20);
  assign un2x = 32'({mag16(side_a[20].geo.n2x), 15'b0}) + 32'(len2_20);
  assign un2y = 32'({mag16(side_a[20].geo.n2y), 15'b0}) + 32'(len2_20);
  assign ud1  = {len1_20, 1'b0};
  assign ud2  = {len2_20, 1'b0};

  lpcd_div #(.NUM_W(32), .DEN_W(18), .Q_W(15)) u_div_u1x (
    .clk(clk), .num(un1x), .den(ud1), .quo(q1x_35)
  );
  lpcd_div #(.NUM_W(32), .DEN_W(18), .Q_W(15)) u_div_u1y (
    .clk(clk), .num(un1y), .den(ud1), .quo(q1y_35)
  );
  lpcd_div #(.NUM_W(32), .DEN_W(18), .Q_W(15)) u_div_u2x (
    .clk(clk), .num(un2x), .den(ud2), .quo(q2x_35)
  );
  lpcd_div #(.NUM_W(32), .DEN_W(18), .Q_W(15)) u_div_u2y (
    .clk(clk), .num(un2y), .den(ud2), .quo(q2y_35)
  );

  function automatic logic signed [15:0] usgn(input logic [14:0] q, input logic neg);
    logic signed [15:0] v;
    v = $signed({1'b0, q});
    return neg ? -v : v;
  endfunction

  // stage 36: orient away from the corner and order left / right
  logic signed [15:0] u1x, u1y, u2x, u2y;
  logic               lf_c;
  logic signed [15:0] lx_36, ly_36, rx_36, ry_36, glx_36, gly_36, grx_36, gry_36;
  logic               ok_36, lf_36;

  always_comb begin
    u1x  = usgn(q1x_35, side_d[35].s1x ^ side_d[35].h1);
    u1y  = usgn(q1y_35, side_d[35].s1y ^ side_d[35].h1);
    u2x  = usgn(q2x_35, side_d[35].s2x ^ side_d[35].h2);
    u2y  = usgn(q2y_35, side_d[35].s2y ^ side_d[35].h2);
    // negative product of both orientations and the cross product
    lf_c = side_d[35].cneg ^ side_d[35].h1 ^ side_d[35].h2;
  end

  always_ff @(posedge clk) begin
    ok_36 <= side_d[35].ok;
    lf_36 <= lf_c;
    if (lf_c) begin
      lx_36 <= u1x;  ly_36 <= u1y;  rx_36 <= u2x;  ry_36 <= u2y;
      glx_36 <= side_d[35].g1x;  gly_36 <= side_d[35].g1y;
      grx_36 <= side_d[35].g2x;  gry_36 <= side_d[35].g2y;
    end else begin
      lx_36 <= u2x;  ly_36 <= u2y;  rx_36 <= u1x;  ry_36 <= u1y;
      glx_36 <= side_d[35].g2x;  gly_36 <= side_d[35].g2y;
      grx_36 <= side_d[35].g1x;  gry_36 <= side_d[35].g1y;
    end
  end

  // stage 37: dot and gradient cross products
  logic signed [31:0] px_37, py_37, gla_37, glb_37, gra_37, grb_37;
  logic signed [15:0] lx_37, ly_37, rx_37, ry_37;
  logic               ok_37, lf_37;

  always_ff @(posedge clk) begin
    px_37  <= lx_36 * rx_36;
    py_37  <= ly_36 * ry_36;
    gla_37 <= glx_36 * ly_36;
    glb_37 <= gly_36 * lx_36;
    gra_37 <= grx_36 * ry_36;
    grb_37 <= gry_36 * rx_36;
    lx_37  <= lx_36;
    ly_37  <= ly_36;
    rx_37  <= rx_36;
    ry_37  <= ry_36;
    ok_37  <= ok_36;
    lf_37  <= lf_36;
  end

  // stage 38: sums
  logic signed [32:0] cos_38, glc_38, grc_38;
  logic signed [15:0] lx_38, ly_38, rx_38, ry_38;
  logic               ok_38, lf_38;

  always_ff @(posedge clk) begin
    cos_38 <= 33'(px_37) + 33'(py_37);
    glc_38 <= 33'(gla_37) - 33'(glb_37);
    grc_38 <= 33'(gra_37) - 33'(grb_37);
    lx_38  <= lx_37;
    ly_38  <= ly_37;
    rx_38  <= rx_37;
    ry_38  <= ry_37;
    ok_38  <= ok_37;
    lf_38  <= lf_37;
  end

  // stage 39: angle windows, gradient sides and output register
  function automatic logic signed [32:0] bnd(input logic signed [15:0] b);
    return $signed({{3{b[15]}}, b, 14'b0});
  endfunction

  logic in_acute, in_obtuse, val;

  always_comb begin
    in_acute  = (cos_38 > bnd(acl)) && (cos_38 < bnd(ach));
    in_obtuse = (cos_38 > bnd(obl)) && (cos_38 < bnd(obh));
    val       = ok_38 && (in_acute || in_obtuse) &&
                (glc_38 > 33'sd0) && (grc_38 < 33'sd0);
  end

  always_ff @(posedge clk) begin
    corner_valid  <= val;
    corner_x      <= val ? cpt[38].x : '0;
    corner_y      <= val ? cpt[38].y : '0;
    left_dir_x    <= val ? lx_38 : '0;
    left_dir_y    <= val ? ly_38 : '0;
    right_dir_x   <= val ? rx_38 : '0;
    right_dir_y   <= val ? ry_38 : '0;
    left_is_first <= val && lf_38;
  end
endmodule
`default_nettype wire
